// ===== sv/sv39_page_table_mapper_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SV39_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define SV39_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SV39PTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SV39PTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sv39ptm_pkg.sv =====
package sv39ptm_pkg;

    localparam int VPN_W         = 27;
    localparam int PPN_W         = 44;
    localparam int PERM_W        = 8;
    localparam int IDX_W         = 9;
    localparam int RPAGE_W       = 4;
    localparam int PTE_W         = 64;
    localparam int PTE_PPN_SHIFT = 10;
    localparam int IN_TDATA_W    = 96;
    localparam int OUT_TDATA_W   = 72;

    localparam logic FUNC_MAP  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VPN_W-1:0]   virt_page;
        logic [PPN_W-1:0]   phys_page;
        logic [PERM_W-1:0]  perm;
        logic               final_page;
        logic [RPAGE_W-1:0] read_page;
        logic [IDX_W-1:0]   read_index;
    } t_request;

    typedef struct packed {
        logic             status;
        logic [1:0]       new_tables;
        logic [PTE_W-1:0] read_data;
        logic             run_done;
    } t_result;

    // Non-leaf entry: PPN of (base + local page), V set.
    function automatic logic [PTE_W-1:0] pointer_entry(input logic [PPN_W-1:0] base,
                                                       input logic [PPN_W-1:0] page);
        logic [PPN_W-1:0] sum;
        sum = base + page;
        return {10'd0, sum, 9'd0, 1'b1};
    endfunction

    function automatic logic [PTE_W-1:0] leaf_entry(input logic [PPN_W-1:0]  ppn,
                                                    input logic [PERM_W-1:0] perm);
        return {10'd0, ppn, 2'd0, perm};
    endfunction

endpackage

// ===== sv/sv39ptm_ram.sv =====
module sv39ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sv39ptm_walk.sv =====
module sv39ptm_walk #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [sv39ptm_pkg::PPN_W-1:0] i_cfg_wdata,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  sv39ptm_pkg::t_request         i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output sv39ptm_pkg::t_result          o_res,
    output logic                          o_ram_en,
    output logic                          o_ram_we,
    output logic [$clog2(TABLE_PAGES)+sv39ptm_pkg::IDX_W-1:0] o_ram_addr,
    output logic [sv39ptm_pkg::PTE_W-1:0] o_ram_wdata,
    input  logic [sv39ptm_pkg::PTE_W-1:0] i_ram_rdata
);

    import sv39ptm_pkg::*;

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);
    localparam int NFW   = $clog2(TABLE_PAGES + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_MID   = 3'd4;
    localparam logic [2:0] S_WMID  = 3'd5;
    localparam logic [2:0] S_WLEAF = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [NFW-1:0]   r_nft, n_nft;
    logic [PPN_W-1:0] r_base;
    t_request         r_req, n_req;
    logic [PW-1:0]    r_mid, n_mid;
    logic [PW-1:0]    r_leaf, n_leaf;
    logic [1:0]       r_used, n_used;
    t_result          r_res, n_res;

    logic [PPN_W-1:0] pte_rel;
    logic             pte_ok;
    logic [PW-1:0]    pte_page;
    logic             room2;
    logic             room1;
    logic             rd_in_range;
    logic [IDX_W-1:0] idx_root, idx_mid, idx_leaf;
    t_result          err_res;

    assign pte_rel     = i_ram_rdata[PTE_PPN_SHIFT +: PPN_W] - r_base;
    assign pte_ok      = (pte_rel != '0) && (pte_rel < PPN_W'(r_nft));
    assign pte_page    = pte_rel[PW-1:0];
    assign room2       = ({1'b0, r_nft} + (NFW+1)'(2)) <= (NFW+1)'(TABLE_PAGES);
    assign room1       = r_nft < NFW'(TABLE_PAGES);
    assign rd_in_range = 9'(r_req.read_page) < 9'(TABLE_PAGES);
    assign idx_root    = r_req.virt_page[26:18];
    assign idx_mid     = r_req.virt_page[17:9];
    assign idx_leaf    = r_req.virt_page[8:0];
    assign err_res     = '{status: ST_ERR, new_tables: 2'd0, read_data: '0,
                           run_done: r_req.final_page};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_nft       = r_nft;
        n_req       = r_req;
        n_mid       = r_mid;
        n_leaf      = r_leaf;
        n_used      = r_used;
        n_res       = r_res;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_clr_addr;
        o_ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ram_en   = 1'b1;
                o_ram_we   = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    o_ram_en = 1'b1;
                    if (i_req.func == FUNC_READ) begin
                        o_ram_addr = {PW'(i_req.read_page), i_req.read_index};
                        n_state    = S_RD;
                    end else begin
                        o_ram_addr = {PW'(0), i_req.virt_page[26:18]};
                        n_state    = S_ROOT;
                    end
                end
            end
            S_RD: begin
                n_res   = '{status: ST_OK, new_tables: 2'd0,
                            read_data: rd_in_range ? i_ram_rdata : '0, run_done: 1'b0};
                n_state = S_RESP;
            end
            S_ROOT: begin
                if (!i_ram_rdata[0]) begin
                    if (room2) begin
                        o_ram_en    = 1'b1;
                        o_ram_we    = 1'b1;
                        o_ram_addr  = {PW'(0), idx_root};
                        o_ram_wdata = pointer_entry(r_base, PPN_W'(r_nft));
                        n_mid       = PW'(r_nft);
                        n_leaf      = PW'(r_nft + NFW'(1));
                        n_used      = 2'd2;
                        n_state     = S_WMID;
                    end else begin
                        n_res   = err_res;
                        n_state = S_RESP;
                    end
                end else if (pte_ok) begin
                    o_ram_en   = 1'b1;
                    o_ram_addr = {pte_page, idx_mid};
                    n_mid      = pte_page;
                    n_state    = S_MID;
                end else begin
                    n_res   = err_res;
                    n_state = S_RESP;
                end
            end
            S_MID: begin
                if (!i_ram_rdata[0]) begin
                    if (room1) begin
                        o_ram_en    = 1'b1;
                        o_ram_we    = 1'b1;
                        o_ram_addr  = {r_mid, idx_mid};
                        o_ram_wdata = pointer_entry(r_base, PPN_W'(r_nft));
                        n_leaf      = PW'(r_nft);
                        n_used      = 2'd1;
                        n_state     = S_WLEAF;
                    end else begin
                        n_res   = err_res;
                        n_state = S_RESP;
                    end
                end else if (pte_ok) begin
                    n_leaf  = pte_page;
                    n_used  = 2'd0;
                    n_state = S_WLEAF;
                end else begin
                    n_res   = err_res;
                    n_state = S_RESP;
                end
            end
            S_WMID: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = {r_mid, idx_mid};
                o_ram_wdata = pointer_entry(r_base, PPN_W'(r_leaf));
                n_state     = S_WLEAF;
            end
            S_WLEAF: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = {r_leaf, idx_leaf};
                o_ram_wdata = leaf_entry(r_req.phys_page, r_req.perm);
                n_nft       = r_nft + NFW'(r_used);
                n_res       = '{status: ST_OK, new_tables: r_used, read_data: '0,
                                run_done: r_req.final_page};
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_nft      <= NFW'(1);
            r_base     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_nft      <= n_nft;
            if (i_cfg_wen) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_mid  <= n_mid;
        r_leaf <= n_leaf;
        r_used <= n_used;
        r_res  <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

endmodule

// ===== sv/sv39ptm_obuf.sv =====
module sv39ptm_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    output logic                 o_res_ready,
    input  sv39ptm_pkg::t_result i_res,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sv39ptm_pkg::t_result o_res
);

    import sv39ptm_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/sv39_page_table_mapper_unit.sv =====
// Sv39 page table mapper.
// Request channel (i_s_axis_*): tuser selects map (0) or read (1); tlast marks the
// last page of a mapping run. A map request installs one 4 KB leaf, allocating
// middle and leaf table pages from a bump pool as needed. A read request returns
// one stored 64-bit entry of the local table memory.
// Response channel (o_m_axis_*): one response per request; tuser is the error
// flag (pool exhausted or stale pointer, nothing written), tlast echoes the
// request's tlast on map responses.
// i_cfg_wen/i_cfg_wdata set the PPN of local page zero; write only while idle.
// Requests are handled one at a time over the single table memory port: a read
// goes through S_RD, a map through S_ROOT, S_MID or S_WMID, then S_WLEAF (ending
// early on error), then waits in S_RESP until the output register takes it.
// After reset the table memory is cleared one entry per cycle, all TABLE_PAGES * 512
// entries, with i_s_axis_tready low; the pool restarts at page one.
// A stalled response holds in the output register; the walker may take one more
// request and then waits in its response state until the register frees.
module sv39_page_table_mapper_unit #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [sv39ptm_pkg::PPN_W-1:0]       i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // virt_page[26:0], phys_page[70:27], perm[78:71], read_page[82:79],
    // read_index[91:83]
    input  logic [sv39ptm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // func
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // new_tables[1:0], read_data[65:2]
    output logic [sv39ptm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    import sv39ptm_pkg::*;

    localparam int AW = $clog2(TABLE_PAGES) + IDX_W;

    t_request         req;
    t_result          walk_res;
    t_result          out_res;
    logic             walk_res_valid;
    logic             walk_res_ready;
    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PTE_W-1:0] ram_wdata;
    logic [PTE_W-1:0] ram_rdata;

    assign req = '{func:       i_s_axis_tuser,
                   virt_page:  i_s_axis_tdata[26:0],
                   phys_page:  i_s_axis_tdata[70:27],
                   perm:       i_s_axis_tdata[78:71],
                   final_page: i_s_axis_tlast,
                   read_page:  i_s_axis_tdata[82:79],
                   read_index: i_s_axis_tdata[91:83]};

    sv39ptm_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (req),
        .o_res_valid (walk_res_valid),
        .i_res_ready (walk_res_ready),
        .o_res       (walk_res),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    sv39ptm_ram #(
        .WIDTH (PTE_W),
        .DEPTH (TABLE_PAGES * (2 ** IDX_W))
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sv39ptm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (walk_res_valid),
        .o_res_ready (walk_res_ready),
        .i_res       (walk_res),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {6'd0, out_res.read_data, out_res.new_tables};
    assign o_m_axis_tuser = out_res.status;
    assign o_m_axis_tlast = out_res.run_done;

endmodule

// ===== sv/sv39ptm_chk.sv =====
`include "sv39_page_table_mapper_unit_macros.svh"

module sv39ptm_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [sv39ptm_pkg::OUT_TDATA_W-1:0] i_out_data,
    input logic                                i_out_user,
    input logic                                i_out_last
);

    import sv39ptm_pkg::*;

    `SV39PTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid, "response dropped while stalled")

    `SV39PTM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        $stable(i_out_data) && $stable(i_out_user) && $stable(i_out_last),
        "response changed while stalled")

    `SV39PTM_ASSERT_NOW(a_new_tables_range, i_clk, i_rst_n, i_out_valid,
        i_out_data[1:0] != 2'd3, "more than two table pages allocated")

    `SV39PTM_ASSERT_NOW(a_error_clean, i_clk, i_rst_n, i_out_valid && i_out_user,
        i_out_data == '0, "error response carries data")

    `SV39PTM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready, "request taken while previous one in progress")

endmodule

bind sv39_page_table_mapper_unit sv39ptm_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_s_axis_tvalid),
    .i_in_ready  (o_s_axis_tready),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata),
    .i_out_user  (o_m_axis_tuser),
    .i_out_last  (o_m_axis_tlast)
);

// ===== sim/sv39_page_table_mapper_unit_tb.sv =====
`timescale 1ns / 100ps

module sv39_page_table_mapper_unit_tb;
    import sv39ptm_pkg::*;

    localparam int TABLE_PAGES = 16;
    localparam int ENTRIES = TABLE_PAGES * 512;
    localparam int IDLE_LIMIT = 50000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [PPN_W-1:0] PPN_ALL = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [PPN_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    always #6 i_clk = ~i_clk;

    sv39_page_table_mapper_unit #(
        .TABLE_PAGES(TABLE_PAGES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // shadow table memory and pool
    logic [PTE_W-1:0] pte_mem [0:ENTRIES-1];
    int unsigned      pool_next;
    logic [PPN_W-1:0] base_ppn;
    int unsigned      touched_q[$];

    t_request    req_q[$];
    t_result     resp_q[$];
    t_request    cur_req;
    t_result     want_resp;
    int unsigned n_pushed = 0;
    int unsigned n_done = 0;
    int unsigned mismatches = 0;
    int          send_gap = 0;
    bit          send_steady = 1'b0;
    int          recv_hold = 0;
    int          stall_draw;
    bit          recv_steady = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [PTE_W-1:0] table_pointer(input int unsigned pg);
        logic [PPN_W-1:0] pg_w;
        logic [PPN_W-1:0] ppn;
        pg_w = PPN_W'(pg);
        ppn = base_ppn + pg_w;
        return {10'd0, ppn, 10'd1};
    endfunction

    // valid pointer -> local page, only if it lies in the allocated pool
    function automatic bit resolve_table(input logic [PTE_W-1:0] pte, output int unsigned pg);
        logic [PPN_W-1:0] rel;
        rel = pte[PTE_PPN_SHIFT +: PPN_W] - base_ppn;
        pg = 32'(rel);
        return (rel != '0) && (rel < pool_next);
    endfunction

    function automatic void store_entry(input int unsigned pg, input int unsigned idx,
                                        input logic [PTE_W-1:0] val);
        pte_mem[pg * 512 + idx] = val;
        touched_q.push_back(pg * 512 + idx);
    endfunction

    function automatic t_result walk_request(input t_request r);
        t_result     res;
        int unsigned i_root;
        int unsigned i_mid;
        int unsigned i_leaf;
        int unsigned mid_pg;
        int unsigned leaf_pg;
        int unsigned used;
        bit          ok;
        res = '0;
        res.status = ST_OK;
        if (r.func == FUNC_READ) begin
            if (r.read_page < TABLE_PAGES) begin
                res.read_data = pte_mem[r.read_page * 512 + r.read_index];
            end
        end else begin
            res.run_done = r.final_page;
            i_root = r.virt_page[26:18];
            i_mid = r.virt_page[17:9];
            i_leaf = r.virt_page[8:0];
            used = 0;
            ok = 1'b1;
            mid_pg = 0;
            leaf_pg = 0;
            if (!pte_mem[i_root][0]) begin
                if (TABLE_PAGES - pool_next < 2) begin
                    ok = 1'b0;
                end else begin
                    mid_pg = pool_next;
                    leaf_pg = pool_next + 1;
                    used = 2;
                    store_entry(0, i_root, table_pointer(mid_pg));
                    store_entry(mid_pg, i_mid, table_pointer(leaf_pg));
                end
            end else if (!resolve_table(pte_mem[i_root], mid_pg)) begin
                ok = 1'b0;
            end else if (!pte_mem[mid_pg * 512 + i_mid][0]) begin
                if (TABLE_PAGES - pool_next < 1) begin
                    ok = 1'b0;
                end else begin
                    leaf_pg = pool_next;
                    used = 1;
                    store_entry(mid_pg, i_mid, table_pointer(leaf_pg));
                end
            end else if (!resolve_table(pte_mem[mid_pg * 512 + i_mid], leaf_pg)) begin
                ok = 1'b0;
            end
            if (ok) begin
                pool_next += used;
                store_entry(leaf_pg, i_leaf, {r.phys_page, 10'd0} + r.perm);
                res.new_tables = 2'(used);
            end else begin
                res.status = ST_ERR;
            end
        end
        return res;
    endfunction

    function automatic logic [PPN_W-1:0] rand_ppn();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PPN_ALL;
            default: return w[PPN_W-1:0];
        endcase
    endfunction

    // read fields carry junk on map requests
    task automatic push_map(input logic [VPN_W-1:0] vpn, input logic [PPN_W-1:0] ppn,
                            input logic fin);
        t_request r;
        r = '0;
        r.func = FUNC_MAP;
        r.virt_page = vpn;
        r.phys_page = ppn;
        r.perm = PERM_W'($urandom_range(0, 255));
        r.final_page = fin;
        r.read_page = RPAGE_W'($urandom_range(0, 15));
        r.read_index = IDX_W'($urandom_range(0, 511));
        req_q.push_back(r);
        n_pushed++;
    endtask

    // map fields carry junk on read requests
    task automatic push_read(input int unsigned pg, input int unsigned idx);
        t_request r;
        r = '0;
        r.func = FUNC_READ;
        r.virt_page = VPN_W'($urandom);
        r.phys_page = rand_ppn();
        r.perm = PERM_W'($urandom_range(0, 255));
        r.final_page = 1'($urandom_range(0, 1));
        r.read_page = RPAGE_W'(pg);
        r.read_index = IDX_W'(idx);
        req_q.push_back(r);
        n_pushed++;
    endtask

    task automatic write_base(input logic [PPN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        base_ppn = v;
    endtask

    task automatic settle();
        while (n_done < n_pushed) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mapping runs over a few hot root/middle slots, plus reads and stray maps
    task automatic random_phase(input int unsigned n_items);
        logic [8:0]       roots [4];
        logic [8:0]       mids [3];
        logic [8:0]       leaf;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        int unsigned      made;
        int unsigned      run_len;
        int unsigned      addr;
        int unsigned      pick;
        made = 0;
        roots[0] = 9'd0;
        roots[1] = 9'h1ff;
        roots[2] = 9'($urandom_range(0, 511));
        roots[3] = 9'($urandom_range(0, 511));
        mids[0] = 9'd0;
        mids[1] = 9'h1ff;
        mids[2] = 9'($urandom_range(0, 511));
        while (made < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                if (touched_q.size() != 0 && $urandom_range(0, 3) != 0) begin
                    addr = touched_q[$urandom_range(0, touched_q.size() - 1)];
                    push_read(addr / 512, addr % 512);
                end else begin
                    push_read($urandom_range(0, 15), $urandom_range(0, 511));
                end
                made++;
            end else if (pick == 2) begin
                push_map(VPN_W'($urandom), rand_ppn(), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                run_len = $urandom_range(1, 6);
                leaf = 9'($urandom_range(0, 511));
                vpn = {roots[$urandom_range(0, 3)], mids[$urandom_range(0, 2)], leaf};
                ppn = rand_ppn();
                for (int k = 0; k < run_len; k++) begin
                    push_map(vpn, ppn, k == run_len - 1);
                    vpn++;
                    ppn++;
                end
                made += run_len;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                resp_q.push_back(walk_request(cur_req));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    i_s_axis_tdata <= {4'd0, cur_req.read_index, cur_req.read_page,
                                       cur_req.perm, cur_req.phys_page,
                                       cur_req.virt_page};
                    i_s_axis_tuser <= cur_req.func;
                    i_s_axis_tlast <= cur_req.final_page;
                    i_s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) send_steady = ~send_steady;
                    send_gap <= send_steady ? 0 : $urandom_range(0, 3);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_hold <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (resp_q.size() == 0) begin
                report_mismatch("unexpected response", o_m_axis_tdata[65:2], '0);
            end else begin
                want_resp = resp_q.pop_front();
                n_done++;
                if (o_m_axis_tuser !== want_resp.status)
                    report_mismatch("status", o_m_axis_tuser, want_resp.status);
                if (o_m_axis_tdata[1:0] !== want_resp.new_tables)
                    report_mismatch("new_tables", o_m_axis_tdata[1:0], want_resp.new_tables);
                if (o_m_axis_tdata[65:2] !== want_resp.read_data)
                    report_mismatch("read_data", o_m_axis_tdata[65:2], want_resp.read_data);
                if (o_m_axis_tlast !== want_resp.run_done)
                    report_mismatch("run_done", o_m_axis_tlast, want_resp.run_done);
            end
            if ($urandom_range(0, 29) == 0) recv_steady = ~recv_steady;
            stall_draw = recv_steady ? 0 : $urandom_range(0, 3);
            if (stall_draw == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                recv_hold <= stall_draw - 1;
            end
        end else if (!i_m_axis_tready) begin
            if (recv_hold == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                recv_hold <= recv_hold - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int a = 0; a < ENTRIES; a++) pte_mem[a] = '0;
        pool_next = 1;
        base_ppn = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-ones base: pointer PPNs wrap around
        write_base(PPN_ALL);
        push_read(0, 0);
        push_map(27'd0, '0, 1'b0);
        push_map(27'd1, PPN_ALL, 1'b1);
        push_map(27'h1ff, rand_ppn(), 1'b0);
        push_map({9'd0, 9'h1ff, 9'd0}, rand_ppn(), 1'b1);
        push_map('1, PPN_ALL, 1'b1);
        push_map('1, '0, 1'b0);
        push_map({9'h1ff, 9'd0, 9'h1ff}, 44'h5555_5555_555, 1'b1);
        push_read(0, 0);
        push_read(0, 511);
        push_read(1, 0);
        push_read(1, 511);
        push_read(2, 0);
        push_read(2, 1);
        push_read(2, 511);
        push_read(3, 0);
        push_read(4, 511);
        push_read(5, 511);
        push_read(6, 511);
        push_read(7, 0);
        push_read(15, 511);
        random_phase(180);
        settle();

        // base changes make older pointers resolve elsewhere or fall outside the pool
        write_base('0);
        random_phase(180);
        settle();

        write_base(rand_ppn());
        random_phase(180);
        settle();

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
